// File: hw/rtl/olt_pkg.sv
package olt_pkg;

	localparam int MAX_OBJECTS_DEF = 1024;
	localparam int HW_W = 23;
	localparam logic [HW_W-1:0] HW_RESET = 23'd2048;
	localparam int IDX_W = 10;

	typedef struct packed {
		logic [7:0] class_id;
		logic [15:0] confidence;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_z;
		logic signed [15:0] rot_x;
		logic signed [15:0] rot_y;
		logic signed [15:0] rot_z;
		logic signed [15:0] rot_w;
	} in_t;

	typedef struct packed {
		logic [IDX_W-1:0] object_index;
		logic is_new;
		logic table_full;
		logic [7:0] out_class;
		logic [15:0] out_confidence;
		logic signed [23:0] out_x;
		logic signed [23:0] out_y;
		logic signed [23:0] out_z;
		logic signed [15:0] out_qx;
		logic signed [15:0] out_qy;
		logic signed [15:0] out_qz;
		logic signed [15:0] out_qw;
	} out_t;

endpackage

// File: hw/rtl/olt_mem.sv
module olt_mem #(
	parameter int DEPTH = olt_pkg::MAX_OBJECTS_DEF,
	parameter int AW = 10
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input olt_pkg::in_t wdata,
	input logic [AW-1:0] raddr,
	output olt_pkg::in_t rdata
);

	olt_pkg::in_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/olt_cmp.sv
module olt_cmp (
	input olt_pkg::in_t item,
	input olt_pkg::in_t entry,
	input logic [olt_pkg::HW_W-1:0] half_width,
	output logic match
);

	function automatic logic near_axis(input logic [23:0] a, input logic [23:0] b,
			input logic [olt_pkg::HW_W-1:0] hw);
		logic signed [24:0] d;
		logic [24:0] mag;
		d = $signed({a[23], a}) - $signed({b[23], b});
		mag = d[24] ? 25'(-d) : 25'(d);
		return mag <= {2'b00, hw};
	endfunction

	assign match = (item.class_id == entry.class_id)
		&& near_axis(item.pos_x, entry.pos_x, half_width)
		&& near_axis(item.pos_y, entry.pos_y, half_width)
		&& near_axis(item.pos_z, entry.pos_z, half_width);

endmodule

// File: hw/rtl/object_location_dedup_table_top.sv
// Object location dedup table.
// Input: pulse start with a detection on item while busy is low; the item is
// transferred at that edge and busy rises for the scan.
// The table is scanned one entry per cycle through the memory read port; the
// last entry of the same class within +/- half-width on every axis wins.
// Output: done is high for exactly one cycle with result: the matched entry
// and its index, or the input echoed with is_new set after it is appended, or
// table_full set (index 0, input echoed) when nothing matches and no room.
// Scan: each stored entry is read once, in index order (none with an empty
// table), so a scan is longer the more entries are stored, MAX_OBJECTS at most.
// busy stays high for the scan and falls as done rises; the next item is taken
// only then. The single memory read port and its registered read set this pace.
// The receiver cannot stall: done and result are valid for that one cycle.
// Configuration: cfg_we writes cfg_wdata into the half-width; write only while idle (the block has no check).
// Reset: the table is empty and half-width is 2048 (0.5 m); no clearing pass.
module object_location_dedup_table_top #(
	parameter int MAX_OBJECTS = olt_pkg::MAX_OBJECTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input olt_pkg::in_t item,
	output logic done,
	output olt_pkg::out_t result,
	input logic cfg_we,
	input logic [olt_pkg::HW_W-1:0] cfg_wdata
);

	localparam int AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
	localparam int CW = $clog2(MAX_OBJECTS + 1);
	localparam int XW = (AW > olt_pkg::IDX_W) ? AW : olt_pkg::IDX_W;
	localparam logic [CW-1:0] FULL_CNT = CW'(MAX_OBJECTS);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	logic state_q;
	logic [olt_pkg::HW_W-1:0] hw_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_cnt_q;
	olt_pkg::in_t item_q;
	logic valid_s1;
	logic [AW-1:0] idx_s1;
	logic found_q;
	logic [AW-1:0] hit_idx_q;
	olt_pkg::in_t hit_entry_q;
	logic done_q;
	olt_pkg::out_t result_q;

	olt_pkg::in_t rdata;
	logic match;
	logic accept;
	logic issue;
	logic scan_end;
	logic append;
	logic [XW-1:0] idx_ext;
	olt_pkg::out_t result_d;

	assign accept = start && (state_q == S_IDLE);
	assign issue = (state_q == S_SCAN) && (rd_cnt_q != count_q);
	assign scan_end = (state_q == S_SCAN) && (rd_cnt_q == count_q) && !valid_s1;
	assign append = scan_end && !found_q && (count_q != FULL_CNT);

	olt_mem #(
		.DEPTH(MAX_OBJECTS),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(append),
		.waddr(count_q[AW-1:0]),
		.wdata(item_q),
		.raddr(rd_cnt_q[AW-1:0]),
		.rdata(rdata)
	);

	olt_cmp u_cmp (
		.item(item_q),
		.entry(rdata),
		.half_width(hw_q),
		.match(match)
	);

	always_comb begin
		result_d.table_full = 1'b0;
		result_d.is_new = 1'b0;
		if (found_q) begin
			idx_ext = XW'(hit_idx_q);
			result_d.out_class = hit_entry_q.class_id;
			result_d.out_confidence = hit_entry_q.confidence;
			result_d.out_x = hit_entry_q.pos_x;
			result_d.out_y = hit_entry_q.pos_y;
			result_d.out_z = hit_entry_q.pos_z;
			result_d.out_qx = hit_entry_q.rot_x;
			result_d.out_qy = hit_entry_q.rot_y;
			result_d.out_qz = hit_entry_q.rot_z;
			result_d.out_qw = hit_entry_q.rot_w;
		end else begin
			if (count_q != FULL_CNT) begin
				idx_ext = XW'(count_q[AW-1:0]);
				result_d.is_new = 1'b1;
			end else begin
				idx_ext = '0;
				result_d.table_full = 1'b1;
			end
			result_d.out_class = item_q.class_id;
			result_d.out_confidence = item_q.confidence;
			result_d.out_x = item_q.pos_x;
			result_d.out_y = item_q.pos_y;
			result_d.out_z = item_q.pos_z;
			result_d.out_qx = item_q.rot_x;
			result_d.out_qy = item_q.rot_y;
			result_d.out_qz = item_q.rot_z;
			result_d.out_qw = item_q.rot_w;
		end
		result_d.object_index = idx_ext[olt_pkg::IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hw_q <= olt_pkg::HW_RESET;
			count_q <= '0;
			rd_cnt_q <= '0;
			valid_s1 <= 1'b0;
			found_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				hw_q <= cfg_wdata;
			end
			valid_s1 <= issue;
			done_q <= scan_end;
			if (issue) begin
				rd_cnt_q <= rd_cnt_q + CW'(1);
			end
			// later matches overwrite earlier ones: highest index wins
			if (valid_s1 && match) begin
				found_q <= 1'b1;
			end
			if (append) begin
				count_q <= count_q + CW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SCAN;
						rd_cnt_q <= '0;
						found_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (scan_end) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		idx_s1 <= rd_cnt_q[AW-1:0];
		if (valid_s1 && match) begin
			hit_idx_q <= idx_s1;
			hit_entry_q <= rdata;
		end
		if (scan_end) begin
			result_q <= result_d;
		end
	end

	assign busy = (state_q == S_SCAN);
	assign done = done_q;
	assign result = result_q;

endmodule

// File: verif/tb_object_location_dedup_table_top.sv
`timescale 1ns / 1ps

module tb_object_location_dedup_table_top;

	localparam int TABLE_DEPTH = olt_pkg::MAX_OBJECTS_DEF;
	localparam int PHASE_ITEMS = 97;
	localparam int PHASES = 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	olt_pkg::in_t item = '0;
	olt_pkg::out_t result;
	logic cfg_we = 1'b0;
	logic [olt_pkg::HW_W-1:0] cfg_wdata = olt_pkg::HW_RESET;

	olt_pkg::in_t detections_q[$];
	olt_pkg::out_t lookups_due[$];
	olt_pkg::out_t lookup_want;
	olt_pkg::in_t known_obj[TABLE_DEPTH];
	int known_count = 0;
	logic [olt_pkg::HW_W-1:0] half_width = olt_pkg::HW_RESET;
	int sender_idle_pct = 0;
	int mismatches = 0;

	object_location_dedup_table_top #(
		.MAX_OBJECTS(TABLE_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic bit in_box(logic signed [23:0] a, logic signed [23:0] b);
		longint diff;
		diff = longint'(a) - longint'(b);
		if (diff < 0)
			diff = -diff;
		return diff <= longint'(half_width);
	endfunction

	// Scan the table, last match wins; otherwise append or flag full.
	function automatic olt_pkg::out_t lookup_object(olt_pkg::in_t d);
		olt_pkg::out_t r;
		olt_pkg::in_t src;
		int hit;
		hit = -1;
		for (int i = 0; i < known_count; i++)
			if (known_obj[i].class_id == d.class_id && in_box(d.pos_x, known_obj[i].pos_x) &&
					in_box(d.pos_y, known_obj[i].pos_y) && in_box(d.pos_z, known_obj[i].pos_z))
				hit = i;
		r = '0;
		src = d;
		if (hit >= 0) begin
			src = known_obj[hit];
			r.object_index = hit[olt_pkg::IDX_W-1:0];
		end else if (known_count < TABLE_DEPTH) begin
			known_obj[known_count] = d;
			r.object_index = known_count[olt_pkg::IDX_W-1:0];
			r.is_new = 1'b1;
			known_count++;
		end else begin
			r.table_full = 1'b1;
		end
		r.out_class = src.class_id;
		r.out_confidence = src.confidence;
		r.out_x = src.pos_x;
		r.out_y = src.pos_y;
		r.out_z = src.pos_z;
		r.out_qx = src.rot_x;
		r.out_qy = src.rot_y;
		r.out_qz = src.rot_z;
		r.out_qw = src.rot_w;
		return r;
	endfunction

	// Move a coordinate inside the box, onto its edge or just past it.
	function automatic logic signed [23:0] nudge(logic signed [23:0] v);
		longint hw;
		longint off;
		longint p;
		hw = longint'(half_width);
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: off = longint'($urandom_range(32'(2 * hw))) - hw;
			6: off = hw;
			7: off = -hw;
			8: off = hw + 1;
			default: off = -hw - 1;
		endcase
		p = longint'(v) + off;
		if (p > 8388607)
			p = 8388607;
		if (p < -8388608)
			p = -8388608;
		return p[23:0];
	endfunction

	function automatic olt_pkg::in_t random_detection();
		olt_pkg::in_t d;
		int unsigned roll;
		int unsigned k;
		roll = $urandom_range(99);
		d.confidence = 16'($urandom);
		d.rot_x = 16'($urandom);
		d.rot_y = 16'($urandom);
		d.rot_z = 16'($urandom);
		d.rot_w = 16'($urandom);
		if (known_count != 0 && roll < 55) begin
			k = $urandom_range(known_count - 1);
			d.class_id = known_obj[k].class_id;
			// same place, other class: must not match this entry
			if (roll >= 47)
				d.class_id = d.class_id + 8'd1;
			d.pos_x = nudge(known_obj[k].pos_x);
			d.pos_y = nudge(known_obj[k].pos_y);
			d.pos_z = nudge(known_obj[k].pos_z);
		end else begin
			d.class_id = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
			if ($urandom_range(1)) begin
				d.pos_x = 24'($urandom);
				d.pos_y = 24'($urandom);
				d.pos_z = 24'($urandom);
			end else begin
				d.pos_x = 24'(int'($urandom_range(65535)) - 32768);
				d.pos_y = 24'(int'($urandom_range(65535)) - 32768);
				d.pos_z = 24'(int'($urandom_range(65535)) - 32768);
			end
		end
		return d;
	endfunction

	function automatic olt_pkg::in_t make_obj(int cls, int conf, int x, int y, int z);
		olt_pkg::in_t d;
		d.class_id = 8'(cls);
		d.confidence = 16'(conf);
		d.pos_x = 24'(x);
		d.pos_y = 24'(y);
		d.pos_z = 24'(z);
		d.rot_x = 16'($urandom);
		d.rot_y = 16'($urandom);
		d.rot_z = 16'($urandom);
		d.rot_w = 16'($urandom);
		return d;
	endfunction

	task automatic send(olt_pkg::in_t d);
		@(negedge clk);
		while (detections_q.size() >= 2)
			@(negedge clk);
		detections_q = {detections_q, d};
	endtask

	// Hold off new items until every pending lookup has returned.
	task automatic drain();
		@(negedge clk);
		while (detections_q.size() != 0 || start || lookups_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_half_width(logic [olt_pkg::HW_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		half_width = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				lookups_due = {lookups_due, lookup_object(item)};
			if (!start || !busy) begin
				if (detections_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					item <= detections_q.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic report_field(string name, logic [23:0] want, logic [23:0] got);
		if (want !== got)
			$display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (lookups_due.size() == 0) begin
				$display("%0t ns: result with no lookup pending, expected none, got %h",
					$time, result);
				mismatches++;
			end else begin
				lookup_want = lookups_due.pop_front();
				if (result !== lookup_want) begin
					mismatches++;
					report_field("object_index", 24'(lookup_want.object_index),
						24'(result.object_index));
					report_field("is_new", 24'(lookup_want.is_new), 24'(result.is_new));
					report_field("table_full", 24'(lookup_want.table_full),
						24'(result.table_full));
					report_field("out_class", 24'(lookup_want.out_class),
						24'(result.out_class));
					report_field("out_confidence", 24'(lookup_want.out_confidence),
						24'(result.out_confidence));
					report_field("out_x", lookup_want.out_x, result.out_x);
					report_field("out_y", lookup_want.out_y, result.out_y);
					report_field("out_z", lookup_want.out_z, result.out_z);
					report_field("out_qx", 24'(lookup_want.out_qx), 24'(result.out_qx));
					report_field("out_qy", 24'(lookup_want.out_qy), 24'(result.out_qy));
					report_field("out_qz", 24'(lookup_want.out_qz), 24'(result.out_qz));
					report_field("out_qw", 24'(lookup_want.out_qw), 24'(result.out_qw));
				end
			end
		end
	end

	initial begin
		olt_pkg::in_t d;
		int unsigned phase_hw[PHASES];
		phase_hw = '{2048, 0, 8388607, 300, 1, 0};
		phase_hw[PHASES-1] = $urandom_range(8388606, 2);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset half-width of 2048.
		send(make_obj(0, 0, 0, 0, 0));
		send(make_obj(0, 65535, 2048, -2048, 2048));
		send(make_obj(0, 1, 2049, 0, 0));
		send(make_obj(0, 2, 0, 0, 2049));
		send(make_obj(0, 3, 0, -2049, 0));
		send(make_obj(1, 4, 0, 0, 0));
		// inside two boxes at once: the later entry wins
		send(make_obj(0, 5, 1024, 0, 0));
		d = make_obj(255, 65535, 8388607, 8388607, 8388607);
		d.rot_x = 16'sh7fff;
		d.rot_y = 16'sh7fff;
		d.rot_z = 16'sh7fff;
		d.rot_w = 16'sh7fff;
		send(d);
		d = make_obj(255, 0, -8388608, -8388608, -8388608);
		d.rot_x = 16'sh8000;
		d.rot_y = 16'sh8000;
		d.rot_z = 16'sh8000;
		d.rot_w = 16'sh8000;
		send(d);
		send(make_obj(255, 7, 8388607 - 2048, 8388607, 8388607 - 100));
		send(make_obj(255, 8, -8388608 + 2048, -8388608, -8388608 + 1));
		send(make_obj(2, 9, -1000, 1000, -1));
		send(make_obj(2, 10, 1000, -1000, 1));
		send(make_obj(2, 11, -3048, 1000, -1));
		send(make_obj(2, 12, -3049, 1000, -1));
		send(make_obj(0, 13, 0, 0, 0));
		send(make_obj(128, 32768, 2048, 2048, 2048));
		drain();

		for (int j = 0; j < PHASES; j++) begin
			sender_idle_pct = (j % 4 == 1) ? 65 : (j % 4 == 3) ? 37 : 0;
			write_half_width(phase_hw[j][olt_pkg::HW_W-1:0]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (j % 2 == 1 && n == PHASE_ITEMS / 2)
					drain();
				send(random_detection());
			end
			drain();
		end

		repeat (TABLE_DEPTH + 4) @(posedge clk);
		if (mismatches == 0)
			$display("object_location_dedup_table_top regression: pass");
		else
			$display("object_location_dedup_table_top regression: fail");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("object_location_dedup_table_top regression: fail");
		$finish;
	end

endmodule

// File: object_location_dedup_table_top.f
hw/rtl/olt_pkg.sv
hw/rtl/olt_mem.sv
hw/rtl/olt_cmp.sv
hw/rtl/object_location_dedup_table_top.sv
verif/tb_object_location_dedup_table_top.sv
